// ===== rtl/cbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbr_pkg - shared definitions for the CEC bit receiver
// Widths, receive phase and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package cbr_pkg;

	// timestamp bits kept from each edge word (16..32)
	localparam int TIME_BITS = 32;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 3;

	localparam logic [3:0] ADDR_UNREG = 4'hF;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_BYTE   = 5'b00010,
		PH_EOM    = 5'b00100,
		PH_ACK    = 5'b01000,
		PH_EOMACK = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_BYTE  = 2'd1,
		EV_END   = 2'd2,
		EV_DRIVE = 2'd3
	} ev_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OWN_ADDR   = 3'd0,
		REG_MONITOR    = 3'd1,
		REG_START_MIN  = 3'd2,
		REG_ONE_MIN    = 3'd3,
		REG_ONE_MAX    = 3'd4,
		REG_GLITCH_MAX = 3'd5
	} cfg_idx_t;

	localparam logic [15:0] START_MIN_RST  = 16'd3500;
	localparam logic [15:0] ONE_MIN_RST    = 16'd400;
	localparam logic [15:0] ONE_MAX_RST    = 16'd800;
	localparam logic [15:0] GLITCH_MAX_RST = 16'd100;

endpackage

// ===== rtl/cec_bit_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_bit_receiver_top - CEC line-edge decoder
// Each edge word is held in the input register; its result word is loaded into
// the result register when the edge word leaves the input register.
// Throughput: one edge word per cycle; a result word held by m_axis_tready
// keeps the next edge word in the input register and drops s_axis_tready.
// Reset (arst_n low): registers return to 15, 0, 3500, 400, 800, 100; the
// line is taken as idle high and the receiver as idle with no header.
// ----------------------------------------------------------------------------
module cec_bit_receiver_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [cbr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbr_pkg::CFG_DATA_W-1:0]     cfg_data,
	// edge words
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [cbr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] line_level, [32:1] edge_time_us
	// result words
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [cbr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [7:0] data_byte, [8] is_header
	output logic [1:0]                         m_axis_tuser   // [1:0] event_kind
);

	localparam int TB = cbr_pkg::TIME_BITS;

	// configuration registers
	logic [3:0]  own_addr_q;
	logic        monitor_q;
	logic [15:0] start_min_q;
	logic [15:0] one_min_q;
	logic [15:0] one_max_q;
	logic [15:0] glitch_max_q;

	// input stage
	logic          in_valid_s1;
	logic          level_s1;
	logic [TB-1:0] now_s1;

	// receiver state
	logic            prev_level_q;
	logic [TB-1:0]   fall_time_q;
	cbr_pkg::phase_t phase_q;
	logic [2:0]      bit_cnt_q;
	logic [7:0]      shift_q;
	logic [3:0]      hdr_dest_q;
	logic            hdr_seen_q;
	logic            ack_q;

	// result register
	logic              out_valid_q;
	cbr_pkg::ev_kind_t kind_q;
	logic [7:0]        byte_q;
	logic              is_hdr_q;

	// next-state logic
	logic              prev_level_d;
	logic [TB-1:0]     fall_time_d;
	cbr_pkg::phase_t   phase_d;
	logic [2:0]        bit_cnt_d;
	logic [7:0]        shift_d;
	logic [3:0]        hdr_dest_d;
	logic              hdr_seen_d;
	logic              ack_d;
	logic              emit;
	cbr_pkg::ev_kind_t kind_d;
	logic [7:0]        byte_d;
	logic              is_hdr_d;
	logic [TB-1:0]     pulse;
	logic              bit_val;
	logic [7:0]        shift_nx;

	logic advance;
	logic fire;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tdata  = {{(cbr_pkg::OUT_TDATA_W - 9){1'b0}}, is_hdr_q, byte_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q   <= cbr_pkg::ADDR_UNREG;
			monitor_q    <= 1'b0;
			start_min_q  <= cbr_pkg::START_MIN_RST;
			one_min_q    <= cbr_pkg::ONE_MIN_RST;
			one_max_q    <= cbr_pkg::ONE_MAX_RST;
			glitch_max_q <= cbr_pkg::GLITCH_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cbr_pkg::REG_OWN_ADDR:   own_addr_q   <= cfg_data[3:0];
				cbr_pkg::REG_MONITOR:    monitor_q    <= cfg_data[0];
				cbr_pkg::REG_START_MIN:  start_min_q  <= cfg_data[15:0];
				cbr_pkg::REG_ONE_MIN:    one_min_q    <= cfg_data[15:0];
				cbr_pkg::REG_ONE_MAX:    one_max_q    <= cfg_data[15:0];
				cbr_pkg::REG_GLITCH_MAX: glitch_max_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			level_s1 <= s_axis_tdata[0];
			now_s1   <= s_axis_tdata[TB:1];
		end
	end

	assign pulse    = now_s1 - fall_time_q;
	assign bit_val  = (pulse >= TB'(one_min_q)) && (pulse <= TB'(one_max_q));
	assign shift_nx = {shift_q[6:0], bit_val};

	always_comb begin
		prev_level_d = prev_level_q;
		fall_time_d  = fall_time_q;
		phase_d      = phase_q;
		bit_cnt_d    = bit_cnt_q;
		shift_d      = shift_q;
		hdr_dest_d   = hdr_dest_q;
		hdr_seen_d   = hdr_seen_q;
		ack_d        = ack_q;
		emit         = 1'b0;
		kind_d       = cbr_pkg::EV_START;
		byte_d       = 8'h00;
		is_hdr_d     = 1'b0;
		if (level_s1 != prev_level_q) begin
			prev_level_d = level_s1;
			if (!level_s1) begin
				fall_time_d = now_s1;
				if (ack_q && !monitor_q) begin
					ack_d  = 1'b0;
					emit   = 1'b1;
					kind_d = cbr_pkg::EV_DRIVE;
				end
			end else if (pulse > TB'(start_min_q)) begin
				phase_d    = cbr_pkg::PH_BYTE;
				bit_cnt_d  = 3'd0;
				shift_d    = 8'h00;
				hdr_seen_d = 1'b0;
				hdr_dest_d = cbr_pkg::ADDR_UNREG;
				ack_d      = 1'b0;
				emit       = 1'b1;
				kind_d     = cbr_pkg::EV_START;
			end else if (pulse >= TB'(glitch_max_q)) begin
				case (phase_q)
					cbr_pkg::PH_BYTE: begin
						shift_d   = shift_nx;
						bit_cnt_d = bit_cnt_q + 3'd1;
						if (bit_cnt_q == 3'd7) begin
							if (!hdr_seen_q) begin
								hdr_dest_d = shift_nx[3:0];
								hdr_seen_d = 1'b1;
							end
							shift_d  = 8'h00;
							phase_d  = cbr_pkg::PH_EOM;
							emit     = 1'b1;
							kind_d   = cbr_pkg::EV_BYTE;
							byte_d   = shift_nx;
							is_hdr_d = !hdr_seen_q;
						end
					end
					cbr_pkg::PH_EOM: begin
						if (hdr_seen_q && hdr_dest_q != cbr_pkg::ADDR_UNREG &&
							hdr_dest_q == own_addr_q) begin
							ack_d = 1'b1;
						end
						if (bit_val) begin
							hdr_seen_d = 1'b0;
							hdr_dest_d = cbr_pkg::ADDR_UNREG;
							bit_cnt_d  = 3'd0;
							shift_d    = 8'h00;
							phase_d    = cbr_pkg::PH_EOMACK;
							emit       = 1'b1;
							kind_d     = cbr_pkg::EV_END;
						end else begin
							phase_d = cbr_pkg::PH_ACK;
						end
					end
					cbr_pkg::PH_ACK:    phase_d = cbr_pkg::PH_BYTE;
					cbr_pkg::PH_EOMACK: phase_d = cbr_pkg::PH_IDLE;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
			fall_time_q  <= '0;
			phase_q      <= cbr_pkg::PH_IDLE;
			bit_cnt_q    <= 3'd0;
			shift_q      <= 8'h00;
			hdr_dest_q   <= cbr_pkg::ADDR_UNREG;
			hdr_seen_q   <= 1'b0;
			ack_q        <= 1'b0;
		end else if (fire) begin
			prev_level_q <= prev_level_d;
			fall_time_q  <= fall_time_d;
			phase_q      <= phase_d;
			bit_cnt_q    <= bit_cnt_d;
			shift_q      <= shift_d;
			hdr_dest_q   <= hdr_dest_d;
			hdr_seen_q   <= hdr_seen_d;
			ack_q        <= ack_d;
		end
	end

	// load the result register whenever the previous word has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q   <= kind_d;
			byte_q   <= byte_d;
			is_hdr_q <= is_hdr_d;
		end
	end

	// bits are only counted while a byte is being shifted in
	a_cnt_in_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_cnt_q != 3'd0) |-> (phase_q == cbr_pkg::PH_BYTE))
		else $error("bit count nonzero outside byte phase");

	// no header means the destination reads as unregistered
	a_hdr_dest: assert property (@(posedge clk) disable iff (!arst_n)
		!hdr_seen_q |-> (hdr_dest_q == cbr_pkg::ADDR_UNREG))
		else $error("header destination set without header");

	// a drive request consumes the pending acknowledge
	a_drive_clears_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && kind_d == cbr_pkg::EV_DRIVE) |=> !ack_q)
		else $error("ack still pending after drive request");

	// byte and header flag only travel with a received byte
	a_payload_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != cbr_pkg::EV_BYTE) |-> (byte_q == 8'h00 && !is_hdr_q))
		else $error("payload on a non-byte event");

endmodule
